// ----- hw/rtl/mwwt_pkg.sv -----
package mwwt_pkg;

  // Table geometry
  localparam int WATCH_ENTRIES = 16;
  localparam int ADDR_BITS     = 48;
  localparam int TAG_BITS      = 16;

  // Fixed port widths
  localparam int IN_CMD_W    = 2;
  localparam int IN_ADDR_W   = 48;
  localparam int IN_SIZE_W   = 32;
  localparam int IN_TAG_W    = 16;
  localparam int OUT_STAT_W  = 3;
  localparam int OUT_TAG_W   = 16;
  localparam int OUT_COUNT_W = 5;

  // Derived widths
  localparam int TAG_W    = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;
  localparam int END_BITS = ADDR_BITS + 1;
  localparam int IDX_BITS = $clog2(WATCH_ENTRIES);
  localparam int CNT_BITS = $clog2(WATCH_ENTRIES + 1);

  // Front-to-back queue
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef enum logic [IN_CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [OUT_STAT_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_HIT      = 3'd5,
    ST_NOHIT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_CHECK,
    OP_IGNORE
  } op_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  // Decoded operation as handed from front to back
  typedef struct packed {
    op_kind_t                kind;
    logic [ADDR_BITS-1:0]    addr;
    logic [IN_SIZE_W-1:0]    size;
    logic [TAG_W-1:0]        tag;
    logic [END_BITS-1:0]     wend;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_rd_t;

endpackage

// ----- hw/rtl/mwwt_front.sv -----
module mwwt_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mwwt_pkg::IN_CMD_W-1:0]  in_cmd,
  input  logic [mwwt_pkg::IN_ADDR_W-1:0] in_addr,
  input  logic [mwwt_pkg::IN_SIZE_W-1:0] in_size,
  input  logic [mwwt_pkg::IN_TAG_W-1:0]  in_tag,
  input  logic                           q_full,
  output mwwt_pkg::q_wr_t                q_wr
);
  import mwwt_pkg::*;

  logic [ADDR_BITS-1:0] addr_m;
  logic                 zero_arg;
  op_kind_t             kind;

  assign addr_m   = in_addr[ADDR_BITS-1:0];
  assign zero_arg = (addr_m == '0) || (in_size == '0);

  // Classify the command; degenerate adds and checks, and the reserved command, collapse to ignore
  always_comb begin
    case (cmd_t'(in_cmd))
      CMD_ADD:    kind = zero_arg ? OP_IGNORE : OP_ADD;
      CMD_REMOVE: kind = OP_REMOVE;
      CMD_CHECK:  kind = zero_arg ? OP_IGNORE : OP_CHECK;
      default:    kind = OP_IGNORE;
    endcase
  end

  // End of region, one bit wider so it never wraps
  assign in_ready        = !q_full;
  assign q_wr.push       = in_valid && !q_full;
  assign q_wr.op.kind    = kind;
  assign q_wr.op.addr    = addr_m;
  assign q_wr.op.size    = in_size;
  assign q_wr.op.tag     = in_tag[TAG_W-1:0];
  assign q_wr.op.wend    = END_BITS'(addr_m) + END_BITS'(in_size);

endmodule

// ----- hw/rtl/mwwt_queue.sv -----
module mwwt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  mwwt_pkg::q_wr_t q_wr,
  output logic            q_full,
  output mwwt_pkg::q_rd_t q_rd,
  input  logic            q_pop
);
  import mwwt_pkg::*;

  op_t                   mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign q_full     = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.op    = mem_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.op;
    end
  end

endmodule

// ----- hw/rtl/mwwt_back.sv -----
module mwwt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mwwt_pkg::q_rd_t                   q_rd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mwwt_pkg::OUT_STAT_W-1:0]   out_status,
  output logic [mwwt_pkg::OUT_TAG_W-1:0]    out_hit_tag,
  output logic [mwwt_pkg::OUT_COUNT_W-1:0]  out_entry_count,
  output logic                              out_last
);
  import mwwt_pkg::*;

  // Lowest set bit of a vector
  function automatic logic [IDX_BITS-1:0] first_idx(input logic [WATCH_ENTRIES-1:0] vec);
    logic [IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = WATCH_ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_BITS'(i);
    end
    return idx;
  endfunction

  // Watch table, no reset: only entries below the count are read
  logic [ADDR_BITS-1:0] start_r [WATCH_ENTRIES];
  logic [IN_SIZE_W-1:0] len_r   [WATCH_ENTRIES];
  logic [END_BITS-1:0]  end_r   [WATCH_ENTRIES];
  logic [TAG_W-1:0]     id_r    [WATCH_ENTRIES];

  logic [CNT_BITS-1:0]      count_r, count_nxt;
  back_state_t              state_r, state_nxt;
  logic [WATCH_ENTRIES-1:0] hits_r, hits_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [TAG_W-1:0]       out_tag_r, out_tag_nxt;
  logic [CNT_BITS-1:0]    out_count_r, out_count_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                     out_load;
  logic                     tbl_full;
  logic [WATCH_ENTRIES-1:0] match_vec, hit_vec, emit_onehot;
  logic [IDX_BITS-1:0]      rm_idx, emit_idx;
  logic                     do_add, do_remove;
  op_t                      op;

  assign op       = q_rd.op;
  assign out_load = !out_valid_r || out_ready;
  assign tbl_full = (count_r == CNT_BITS'(WATCH_ENTRIES));

  // Parallel compare of every live entry
  always_comb begin
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      match_vec[i] = (CNT_BITS'(i) < count_r) && (start_r[i] == op.addr)
                     && (len_r[i] == op.size) && (id_r[i] == op.tag);
      hit_vec[i]   = (CNT_BITS'(i) < count_r) && (op.wend > END_BITS'(start_r[i]))
                     && (end_r[i] > END_BITS'(op.addr));
    end
  end

  assign rm_idx      = first_idx(match_vec);
  assign emit_idx    = first_idx(hits_r);
  assign emit_onehot = WATCH_ENTRIES'(1) << emit_idx;

  // Sequencer: one result per op, or one per hit for checks
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    hits_nxt       = hits_r;
    q_pop          = 1'b0;
    do_add         = 1'b0;
    do_remove      = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_rd.valid && out_load) begin
          q_pop        = 1'b1;
          out_tag_nxt  = '0;
          out_last_nxt = 1'b1;
          case (op.kind)
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (tbl_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                do_add         = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = ST_ADDED;
              end
            end
            OP_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (|match_vec) begin
                do_remove      = 1'b1;
                count_nxt      = count_r - 1'b1;
                out_status_nxt = ST_REMOVED;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            OP_CHECK: begin
              if (|hit_vec) begin
                hits_nxt  = hit_vec;
                state_nxt = BK_EMIT;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOHIT;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_IGNORED;
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      BK_EMIT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_HIT;
          out_tag_nxt    = id_r[emit_idx];
          out_count_nxt  = count_r;
          hits_nxt       = hits_r & ~emit_onehot;
          out_last_nxt   = (hits_nxt == '0);
          if (hits_nxt == '0) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r      <= hits_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Table update: append at the count, or close up above the removed entry
  always_ff @(posedge clk) begin
    if (do_add) begin
      start_r[count_r[IDX_BITS-1:0]] <= op.addr;
      len_r[count_r[IDX_BITS-1:0]]   <= op.size;
      end_r[count_r[IDX_BITS-1:0]]   <= END_BITS'(op.addr) + END_BITS'(op.size);
      id_r[count_r[IDX_BITS-1:0]]    <= op.tag;
    end else if (do_remove) begin
      for (int j = 0; j < WATCH_ENTRIES - 1; j++) begin
        if (IDX_BITS'(j) >= rm_idx) begin
          start_r[j] <= start_r[j+1];
          len_r[j]   <= len_r[j+1];
          end_r[j]   <= end_r[j+1];
          id_r[j]    <= id_r[j+1];
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit_tag     = OUT_TAG_W'(out_tag_r);
  assign out_entry_count = OUT_COUNT_W'(out_count_r);
  assign out_last        = out_last_r;

endmodule

// ----- hw/rtl/memory_write_watch_table.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// in_      | in_valid / in_ready   | in_cmd, in_addr, in_size, in_tag
// out_     | out_valid / out_ready | out_status, out_hit_tag, out_entry_count,
//          |                       | out_last
//
// Add, remove and ignored operations each give one result from the back end.
// A write check gives one result per hit after its compare, and a miss gives a
// single no-hit result; no new operation is taken until the last hit is out.
// The pace is set by the single result register and the hit scan.
// A two-entry queue lets input transactions land while results are stalled.
// Reset empties the table and the queue; no clearing pass is needed.
module memory_write_watch_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mwwt_pkg::IN_CMD_W-1:0]     in_cmd,
  input  logic [mwwt_pkg::IN_ADDR_W-1:0]    in_addr,
  input  logic [mwwt_pkg::IN_SIZE_W-1:0]    in_size,
  input  logic [mwwt_pkg::IN_TAG_W-1:0]     in_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mwwt_pkg::OUT_STAT_W-1:0]   out_status,
  output logic [mwwt_pkg::OUT_TAG_W-1:0]    out_hit_tag,
  output logic [mwwt_pkg::OUT_COUNT_W-1:0]  out_entry_count,
  output logic                              out_last
);
  import mwwt_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Decode and classify
  mwwt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_addr  (in_addr),
    .in_size  (in_size),
    .in_tag   (in_tag),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // Decoupling queue
  mwwt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // Table and result sequencer
  mwwt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_hit_tag     (out_hit_tag),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

// ----- hw/rtl/mwwt_checker.sv -----
module mwwt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mwwt_pkg::OUT_STAT_W-1:0]   out_status,
  input logic [mwwt_pkg::OUT_TAG_W-1:0]    out_hit_tag,
  input logic [mwwt_pkg::OUT_COUNT_W-1:0]  out_entry_count,
  input logic                              out_last
);
  import mwwt_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_hit_tag) && $stable(out_last))
    else $error("result changed while stalled");

  // Every non-hit result is the single, final one and carries no tag
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_HIT) |-> out_last && (out_hit_tag == '0))
    else $error("non-hit result not final or tagged");

  // Count never exceeds the table depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= OUT_COUNT_W'(WATCH_ENTRIES))
    else $error("entry count out of range");

  // A hit or a successful add implies a non-empty table
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_HIT) || (out_status == ST_ADDED))
      |-> out_entry_count != '0)
    else $error("hit or add with empty table");

  // A table-full result reports a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL)
      |-> out_entry_count == OUT_COUNT_W'(WATCH_ENTRIES))
    else $error("table full reported below depth");

endmodule

bind memory_write_watch_table mwwt_checker u_mwwt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_hit_tag     (out_hit_tag),
  .out_entry_count (out_entry_count),
  .out_last        (out_last)
);
